// ===== design/a85v_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package a85v_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_FIRST = 8'd33;
  localparam logic [7:0] CHAR_LAST  = 8'h75;  // 'u'
  localparam logic [7:0] CHAR_W     = 8'h77;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_Y     = 8'h79;
  localparam logic [7:0] CHAR_Z     = 8'h7A;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_BAR   = 8'h7C;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;

  localparam logic [2:0] GROUP_DIGITS = 3'd5;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_message;
    logic       decode_error;
  } out_t;

  // One accepted character's worth of results: an optional full word, an
  // optional 1..3 byte tail word, then an optional byte-less marker.
  typedef struct packed {
    logic        word_en;
    logic [31:0] word;
    logic [1:0]  tail_bytes;
    logic [31:0] tail_word;
    logic        marker;
    logic        err;
    logic        eom;
  } cmd_t;

  function automatic logic [31:0] digit_weight(input logic [2:0] pos);
    case (pos)
      3'd0:    digit_weight = 32'd52200625;  // 85^4
      3'd1:    digit_weight = 32'd614125;    // 85^3
      3'd2:    digit_weight = 32'd7225;
      3'd3:    digit_weight = 32'd85;
      default: digit_weight = 32'd1;
    endcase
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    case (idx)
      2'd0:    word_byte = w[31:24];
      2'd1:    word_byte = w[23:16];
      2'd2:    word_byte = w[15:8];
      default: word_byte = w[7:0];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/a85v_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a85v_front import a85v_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  input  wire logic q_full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;

  logic [7:0]  c;
  logic        eob, accept;
  logic        is_sh, is_ws, is_digit;
  logic [31:0] sh_word, acc_sum, acc1;
  logic [2:0]  cnt1;
  logic [7:0]  dig_full;
  logic [6:0]  dig;
  cmd_t        cmd;

  assign c      = in_data_i.in_char;
  assign eob    = in_data_i.end_of_buffer;
  assign accept = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    is_sh   = 1'b1;
    sh_word = 32'h0000_0000;
    case (c)
      CHAR_Z:      sh_word = 32'h0000_0000;
      CHAR_Y:      sh_word = 32'hFFFF_FFFF;
      CHAR_X:      sh_word = 32'h0000_00FF;
      CHAR_LBRACE: sh_word = 32'h0000_FFFF;
      CHAR_BAR:    sh_word = 32'h00FF_00FF;
      CHAR_RBRACE: sh_word = 32'hFF00_00FF;
      default:     is_sh = 1'b0;
    endcase
  end

  assign is_ws    = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
  assign is_digit = (c == CHAR_W) || ((c >= CHAR_FIRST) && (c <= CHAR_LAST));
  assign dig_full = (c == CHAR_W) ? 8'd1 : (c - CHAR_FIRST);
  assign dig      = dig_full[6:0];
  assign acc_sum  = acc_q + ({25'b0, dig} * digit_weight(cnt_q));

  always_comb begin
    cmd    = '0;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    disc_d = disc_q;
    acc1   = acc_q;
    cnt1   = cnt_q;
    if (disc_q) begin
      if (eob) begin
        cmd.marker = 1'b1;
        cmd.err    = 1'b1;
        cmd.eom    = 1'b1;
        acc_d  = '0;
        cnt_d  = '0;
        disc_d = 1'b0;
      end
    end else if (!is_sh && !is_ws && !is_digit) begin
      // invalid character: report it, drop the group, skip to the end mark
      cmd.marker = 1'b1;
      cmd.err    = 1'b1;
      cmd.eom    = eob;
      acc_d  = '0;
      cnt_d  = '0;
      disc_d = !eob;
    end else begin
      if (is_sh) begin
        cmd.word_en = 1'b1;
        cmd.word    = sh_word;
      end else if (is_digit) begin
        cnt1 = cnt_q + 3'd1;
        acc1 = acc_sum;
        if (cnt1 == GROUP_DIGITS) begin
          cmd.word_en = 1'b1;
          cmd.word    = acc_sum;
          acc1 = '0;
          cnt1 = '0;
        end
      end
      acc_d = acc1;
      cnt_d = cnt1;
      if (eob) begin
        if (cnt1 >= 3'd2) begin
          cmd.tail_bytes = 2'(cnt1 - 3'd1);
          cmd.tail_word  = acc1 + digit_weight(cnt1 - 3'd1);
        end
        cmd.marker = !cmd.word_en && (cnt1 < 3'd2);
        cmd.eom    = 1'b1;
        acc_d = '0;
        cnt_d = '0;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.word_en || (cmd.tail_bytes != 2'd0) || cmd.marker);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      disc_q <= 1'b0;
    end else if (accept) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/a85v_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a85v_queue import a85v_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  cmd_t                 slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_pop;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/a85v_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a85v_back import a85v_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_t       out_q;

  logic [2:0] total, tail_idx;
  logic       last, load;
  out_t       res;

  assign total = (cmd_i.word_en ? 3'd4 : 3'd0) + {1'b0, cmd_i.tail_bytes}
               + {2'b0, cmd_i.marker};
  assign last  = (idx_q == total - 3'd1);
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && cmd_valid_i && last;
  assign tail_idx = idx_q - (cmd_i.word_en ? 3'd4 : 3'd0);

  always_comb begin
    res = '0;
    if (cmd_i.word_en && (idx_q < 3'd4)) begin
      res.out_byte = word_byte(cmd_i.word, idx_q[1:0]);
      res.has_byte = 1'b1;
    end else if (tail_idx < {1'b0, cmd_i.tail_bytes}) begin
      res.out_byte = word_byte(cmd_i.tail_word, tail_idx[1:0]);
      res.has_byte = 1'b1;
    end else begin
      res.decode_error = cmd_i.err;
    end
    res.end_of_message = cmd_i.eom && last;
  end

  always_ff @(posedge clk_i) begin
    if (load && cmd_valid_i) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        // advance within the command, restart on its last result
        idx_q <= last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/ascii85_variant_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ascii85-style decoder, one character per input transaction, one decoded
// byte (or byte-less status result) per output transaction. The front end
// takes a character every cycle while its four-entry command queue has room;
// the back end drains one result per cycle while the output is not stalled,
// and each character's results leave in turn (four for a completed group or a
// shorthand letter, up to seven when a shorthand letter also closes the
// buffer). Input stalls only when that queue fills. Whitespace and
// non-final digits produce no result. An invalid character yields one
// result with decode_error set, and characters are then dropped until the
// end mark, which closes with end_of_message and decode_error both set.
module ascii85_variant_decoder import a85v_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic push, full, pop, cmd_valid;
  cmd_t push_cmd, head_cmd;

  a85v_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  a85v_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .data_o      (head_cmd)
  );

  a85v_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_ascii85_variant_decoder.sv =====
`timescale 1ns / 1ps

import a85v_pkg::*;

class a85_byte_scoreboard;
  out_t        expected_q[$];
  logic [31:0] group_acc;
  logic [2:0]  digits;
  bit          skipping;
  int          fails;

  function new();
    group_acc = '0;
    digits    = '0;
    skipping  = 1'b0;
    fails     = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void clear_group();
    group_acc = '0;
    digits    = '0;
    skipping  = 1'b0;
  endfunction

  function logic [31:0] place_value(input logic [2:0] pos);
    logic [31:0] v;
    int          k;
    v = 32'd1;
    for (k = pos; k < 4; k++) v = v * 32'd85;
    return v;
  endfunction

  function void push_byte(input logic [7:0] b, input bit has, input bit err);
    out_t r;
    r.out_byte       = b;
    r.has_byte       = has;
    r.end_of_message = 1'b0;
    r.decode_error   = err;
    expected_q.push_back(r);
  endfunction

  function void push_word(input logic [31:0] w, input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) push_byte(w[31 - 8 * i -: 8], 1'b1, 1'b0);
  endfunction

  // flag the newest expected result as the end of the message
  function void close_message();
    out_t r;
    r = expected_q.pop_back();
    r.end_of_message = 1'b1;
    expected_q.push_back(r);
  endfunction

  function void note_char(input in_t item);
    logic [31:0] digit;
    int          first;
    bit          eob;
    first = expected_q.size();
    eob   = item.end_of_buffer;
    digit = '0;
    if (digits > 3'd4) digits = '0;
    if (!skipping) begin
      case (item.in_char)
        CHAR_Z:      push_word(32'h0000_0000, 4);
        CHAR_Y:      push_word(32'hFFFF_FFFF, 4);
        CHAR_X:      push_word(32'h0000_00FF, 4);
        CHAR_LBRACE: push_word(32'h0000_FFFF, 4);
        CHAR_BAR:    push_word(32'h00FF_00FF, 4);
        CHAR_RBRACE: push_word(32'hFF00_00FF, 4);
        CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR: ;
        default: begin
          if (item.in_char == CHAR_W) begin
            digit = 32'd1;
          end else if (item.in_char >= CHAR_FIRST && item.in_char <= CHAR_LAST) begin
            digit = item.in_char - CHAR_FIRST;
          end else begin
            // report the bad character, then drop input until the end mark
            push_byte(8'h00, 1'b0, 1'b1);
            clear_group();
            if (eob) close_message();
            else skipping = 1'b1;
            return;
          end
          group_acc = group_acc + digit * place_value(digits);
          digits    = digits + 3'd1;
          if (digits == GROUP_DIGITS) begin
            push_word(group_acc, 4);
            group_acc = '0;
            digits    = '0;
          end
        end
      endcase
    end
    if (!eob) return;
    if (skipping) begin
      push_byte(8'h00, 1'b0, 1'b1);
      close_message();
      clear_group();
      return;
    end
    // pad a partial group and emit its leading bytes
    if (digits >= 3'd2) begin
      group_acc = group_acc + place_value(digits - 3'd1);
      push_word(group_acc, digits - 1);
    end
    if (expected_q.size() == first) push_byte(8'h00, 1'b0, 1'b0);
    close_message();
    clear_group();
  endfunction

  function void compare_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fails++;
    end
  endfunction

  function void check_result(input out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      fails++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("has_byte", want.has_byte, got.has_byte);
    compare_field("end_of_message", want.end_of_message, got.end_of_message);
    compare_field("decode_error", want.decode_error, got.decode_error);
  endfunction
endclass

module tb_ascii85_variant_decoder;

  localparam int         WatchdogLimit = 2000;
  localparam int         RandomItems   = 80;
  localparam logic [7:0] CHAR_V        = 8'h76;
  localparam logic [7:0] CHAR_TILDE    = 8'h7E;
  localparam logic [7:0] CHAR_DEL      = 8'h7F;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  a85_byte_scoreboard sb;
  bit calm_in;
  bit calm_out;
  int stall_left;
  int idle_cycles;

  ascii85_variant_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sample both channels at the rising edge, inputs first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        sb.note_char(in_data_i);
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        stall_left  = calm_out ? 0 : $urandom_range(0, 13);
        idle_cycles = 0;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // enter and leave at a falling edge
  task automatic send_char(input logic [7:0] c, input bit eob);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {c, eob};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit close);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // let a dropped-only character finish inside the block
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char(input bit noisy);
    int r;
    r = $urandom_range(0, 99);
    if (noisy && r < 20) begin
      case ($urandom_range(0, 2))
        0:       return 8'($urandom_range(128, 255));
        1:       return 8'($urandom_range(0, 32));
        default: begin
          case ($urandom_range(0, 2))
            0:       return CHAR_V;
            1:       return CHAR_TILDE;
            default: return CHAR_DEL;
          endcase
        end
      endcase
    end
    if (r < 65) return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
    if (r < 70) return CHAR_W;
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0:       return CHAR_Z;
        1:       return CHAR_Y;
        2:       return CHAR_X;
        3:       return CHAR_LBRACE;
        4:       return CHAR_BAR;
        default: return CHAR_RBRACE;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      default: return CHAR_CR;
    endcase
  endfunction

  initial begin
    int len;
    int k;
    int sent;
    bit noisy;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    calm_in     = 1'b0;
    calm_out    = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    sent        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // largest group wraps; shorthand mid-group; end mark on a shorthand
    send_text("uuuuu", 1'b0);
    send_text("!w {|\txuuz", 1'b1);
    send_text("y}!!!", 1'b1);
    // bad character, then the end mark; then one-character messages
    send_char(8'hFF, 1'b0);
    send_char("a", 1'b1);
    send_char(CHAR_V, 1'b1);
    send_char(CHAR_FIRST, 1'b1);
    send_char(CHAR_CR, 1'b1);
    pause_until_drained();

    while (sent < RandomItems) begin
      len      = $urandom_range(1, 12);
      noisy    = ($urandom_range(0, 3) == 0);
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      for (k = 0; k < len; k++) send_char(pick_char(noisy), k == len - 1);
      sent = sent + len;
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
